FILE: sv/gad_pkg.sv
// Shared types and constants for the galvo angle to DAC word block.
package gad_pkg;

    // Input item: command code and X/Y angles in signed Q8.8 degrees
    typedef struct packed {
        logic               func;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
    } s_item_t;

    // Result item: one DAC command word with status and end-of-item flag
    typedef struct packed {
        logic [31:0] spi_word;
        logic        status;
        logic        last;
    } m_item_t;

    // Configuration register contents
    typedef struct packed {
        logic               differential_wiring;
        logic [3:0]         xp_chan;
        logic [3:0]         xm_chan;
        logic [3:0]         yp_chan;
        logic [3:0]         ym_chan;
        logic signed [19:0] codes_per_degree;
    } cfg_t;

    // What the product stage hands on to the result sequencer
    typedef enum logic [1:0] {
        KIND_ENABLE,
        KIND_ERROR,
        KIND_ANGLE
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [35:0] sx;
        logic signed [35:0] sy;
    } prod_t;

    // Command codes
    localparam logic FUNC_ENABLE = 1'b0;

    // Register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFERENTIAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_PLUS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MINUS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_PLUS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MINUS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 3'd5;

    // Register reset values
    localparam logic [3:0]         RST_X_PLUS  = 4'd0;
    localparam logic [3:0]         RST_X_MINUS = 4'd1;
    localparam logic [3:0]         RST_Y_PLUS  = 4'd2;
    localparam logic [3:0]         RST_Y_MINUS = 4'd3;
    localparam logic signed [19:0] RST_GAIN    = 20'sd419430;

    // DAC command words
    localparam logic [31:0] ENABLE_REF_WORD = 32'h0800_0001;
    localparam logic [7:0]  WRITE_CONTROL   = 8'h03;

    // Mid-scale 32767.5 plus one half for rounding, in units of 1/65536 code
    localparam logic signed [36:0] ROUND_OFFSET = 37'sh0_8000_0000;

endpackage

FILE: sv/gad_cfg.sv
// Configuration register file for the galvo angle to DAC word block.
module gad_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [gad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gad_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output gad_pkg::cfg_t                 cfg
);
    import gad_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; unknown indexes leave everything as is
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_DIFFERENTIAL: cfg_next.differential_wiring = cfg_wdata[0];
                CFG_X_PLUS:       cfg_next.xp_chan = cfg_wdata[3:0];
                CFG_X_MINUS:      cfg_next.xm_chan = cfg_wdata[3:0];
                CFG_Y_PLUS:       cfg_next.yp_chan = cfg_wdata[3:0];
                CFG_Y_MINUS:      cfg_next.ym_chan = cfg_wdata[3:0];
                CFG_GAIN:         cfg_next.codes_per_degree = $signed(cfg_wdata);
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.differential_wiring <= 1'b0;
            cfg_reg.xp_chan             <= RST_X_PLUS;
            cfg_reg.xm_chan             <= RST_X_MINUS;
            cfg_reg.yp_chan             <= RST_Y_PLUS;
            cfg_reg.ym_chan             <= RST_Y_MINUS;
            cfg_reg.codes_per_degree    <= RST_GAIN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/gad_scale.sv
// Input register, reference flag and angle-times-gain product register.
module gad_scale (
    input  logic             aclk,
    input  logic             aresetn,
    input  gad_pkg::cfg_t    cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  gad_pkg::s_item_t s_item,
    output logic             prod_valid,
    input  logic             prod_ready,
    output gad_pkg::prod_t   prod
);
    import gad_pkg::*;

    logic    in_valid_reg;
    s_item_t in_item_reg;
    logic    prod_valid_reg;
    prod_t   prod_reg;
    prod_t   prod_next;
    logic    ref_on_reg;
    logic    prod_load;
    logic    in_load;

    // Stage handshakes: each register frees when its contents move on
    assign prod_load = in_valid_reg && (!prod_valid_reg || prod_ready);
    assign s_ready   = !in_valid_reg || prod_load;
    assign in_load   = s_valid && s_ready;

    // Classify the item and form both products
    always_comb begin
        prod_next.sx = 36'($signed(in_item_reg.angle_x) * $signed(cfg.codes_per_degree));
        prod_next.sy = 36'($signed(in_item_reg.angle_y) * $signed(cfg.codes_per_degree));
        if (in_item_reg.func == FUNC_ENABLE) begin
            prod_next.kind = KIND_ENABLE;
        end else if (!ref_on_reg) begin
            prod_next.kind = KIND_ERROR;
        end else begin
            prod_next.kind = KIND_ANGLE;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            ref_on_reg     <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (prod_load) begin
                prod_valid_reg <= 1'b1;
                if (in_item_reg.func == FUNC_ENABLE) begin
                    ref_on_reg <= 1'b1;
                end
            end else if (prod_ready) begin
                prod_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_item_reg <= s_item;
        end
        if (prod_load) begin
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

    // Once the reference is on it stays on until reset
    a_ref_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ref_on_reg |=> ref_on_reg)
        else $error("reference flag dropped");

    // An angle pair only reaches the sequencer after the reference is on
    a_angle_needs_ref: assert property (@(posedge aclk) disable iff (!aresetn)
        prod_valid_reg && prod_reg.kind == KIND_ANGLE |-> ref_on_reg)
        else $error("angle item without reference");

endmodule

FILE: sv/gad_emit.sv
// Result sequencer: turns one product item into its DAC words, one per cycle while m_ready does not stall the output.
module gad_emit (
    input  logic             aclk,
    input  logic             aresetn,
    input  gad_pkg::cfg_t    cfg,
    input  logic             prod_valid,
    output logic             prod_ready,
    input  gad_pkg::prod_t   prod,
    output logic             m_valid,
    input  logic             m_ready,
    output gad_pkg::m_item_t m_item
);
    import gad_pkg::*;

    logic               m_valid_reg;
    m_item_t            m_item_reg;
    m_item_t            m_item_next;
    logic [1:0]         idx_reg;
    logic [1:0]         idx_next;
    logic [1:0]         slot;
    logic               is_last;
    logic               out_load;
    logic [3:0]         chan;
    logic signed [36:0] sel_w;
    logic signed [36:0] scaled_w;
    logic signed [36:0] sum_w;
    logic [15:0]        code;

    assign out_load = prod_valid && (!m_valid_reg || m_ready);

    // Slot: bit 1 picks Y, bit 0 picks the minus channel
    assign slot = cfg.differential_wiring ? idx_reg : {idx_reg[0], 1'b0};

    always_comb begin
        if (prod.kind != KIND_ANGLE) begin
            is_last = 1'b1;
        end else if (cfg.differential_wiring) begin
            is_last = (idx_reg == 2'd3);
        end else begin
            is_last = (idx_reg == 2'd1);
        end
    end

    assign prod_ready = out_load && is_last;
    assign idx_next   = is_last ? 2'd0 : idx_reg + 2'd1;

    // Negate for a minus channel, then offset, round and saturate the selected product
    always_comb begin
        sel_w    = slot[1] ? 37'($signed(prod.sy)) : 37'($signed(prod.sx));
        scaled_w = slot[0] ? -sel_w : sel_w;
        sum_w    = scaled_w + ROUND_OFFSET;
        if (sum_w[36]) begin
            code = 16'h0000;
        end else if (|sum_w[35:32]) begin
            code = 16'hFFFF;
        end else begin
            code = sum_w[31:16];
        end
    end

    always_comb begin
        unique case (slot)
            2'd0:    chan = cfg.xp_chan;
            2'd1:    chan = cfg.xm_chan;
            2'd2:    chan = cfg.yp_chan;
            default: chan = cfg.ym_chan;
        endcase
    end

    // Build the result word
    always_comb begin
        m_item_next.last = is_last;
        unique case (prod.kind)
            KIND_ENABLE: begin
                m_item_next.spi_word = ENABLE_REF_WORD;
                m_item_next.status   = 1'b0;
            end
            KIND_ERROR: begin
                m_item_next.spi_word = 32'h0000_0000;
                m_item_next.status   = 1'b1;
            end
            default: begin
                m_item_next.spi_word = {WRITE_CONTROL, chan, code, 4'h0};
                m_item_next.status   = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= idx_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Enable and error items never run past their first word
    a_single_word: assert property (@(posedge aclk) disable iff (!aresetn)
        prod_valid && prod.kind != KIND_ANGLE |-> idx_reg == 2'd0)
        else $error("single-word item at nonzero index");

    // An error result is a lone zero word
    a_error_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.status |-> m_item_reg.last && m_item_reg.spi_word == 32'h0)
        else $error("malformed error result");

    // The product item is released only together with its final word
    a_release_last: assert property (@(posedge aclk) disable iff (!aresetn)
        prod_ready |=> m_valid_reg && m_item_reg.last)
        else $error("product released before final word");

endmodule

FILE: sv/galvo_angle_to_dac_words.sv
// Galvo angle to DAC word converter, top level.
// An enable command (func 0) sends the internal-reference word 0x08000001 and
// arms the block; an angle pair (func 1) sent before that gets one zero word
// with status 1. An armed angle pair gives X+ then Y+ words, or X+, X-, Y+, Y-
// with differential wiring (angle negated for X- and Y-), each code =
// round(angle * codes_per_degree/256 + 32767.5) clamped to 0..65535, packed
// as control 3, channel, code, 4'b0. Items pass the input, product and result
// registers. The result register takes one word per cycle while m_ready does
// not stall it, so an enable or error item gives one word, an angle pair two
// (single-ended) or four (differential); items are accepted back to back as
// words drain. Write the configuration only while no item is in flight.
module galvo_angle_to_dac_words (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [gad_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gad_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  gad_pkg::s_item_t                s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output gad_pkg::m_item_t                m_item
);
    import gad_pkg::*;

    cfg_t  cfg;
    prod_t prod;
    logic  prod_valid;
    logic  prod_ready;

    gad_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    gad_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod)
    );

    gad_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule
